>>> hw/rtl/clsr_pkg.sv
// Shared constants and types for the combined LCG shuffle random generator.
`default_nettype none

package clsr_pkg;

  localparam int unsigned VAL_W = 31;

  // Generator moduli are 2^31 - fold constant.
  localparam logic [31:0] MOD_ONE = 32'd2147483563;
  localparam logic [31:0] MOD_TWO = 32'd2147483399;
  localparam logic [7:0]  FOLD_ONE = 8'd85;
  localparam logic [7:0]  FOLD_TWO = 8'd249;
  localparam logic [15:0] MUL_ONE = 16'd40014;
  localparam logic [15:0] MUL_TWO = 16'd40692;

  localparam logic [VAL_W-1:0] TOP_VALUE = 31'd2147483562;
  localparam int unsigned WARM_EXTRA = 8;
  localparam int unsigned TABLE_SIZE_DEF = 32;

  typedef enum logic {
    GEN_ONE,
    GEN_TWO
  } gen_sel_t;

  typedef struct packed {
    logic             valid;
    gen_sel_t         sel;
    logic [VAL_W-1:0] x;
  } mm_req_t;

  typedef struct packed {
    logic             valid;
    gen_sel_t         sel;
    logic [VAL_W-1:0] res;
  } mm_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/clsr_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module clsr_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire  [$clog2(DEPTH)-1:0] wr_addr,
  input  wire  [WIDTH-1:0]         wr_data,
  input  wire  [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/clsr_mulmod.sv
// Shared modular multiply unit: x * mul mod (2^31 - c), two-stage pipeline.
`default_nettype none

module clsr_mulmod (
  input  wire               clk,
  input  wire               rst_n,
  input  clsr_pkg::mm_req_t req,
  output clsr_pkg::mm_rsp_t rsp
);

  import clsr_pkg::*;

  logic [46:0] prod_r;
  logic        v1_r;
  gen_sel_t    sel1_r;
  logic [31:0] sum_r;
  logic        v2_r;
  gen_sel_t    sel2_r;

  logic [15:0] mul;
  logic [7:0]  fold;
  logic [23:0] hi_fold;
  logic [31:0] modulus;
  logic [31:0] reduced;

  assign mul     = (req.sel == GEN_TWO) ? MUL_TWO : MUL_ONE;
  assign fold    = (sel1_r == GEN_TWO) ? FOLD_TWO : FOLD_ONE;
  // 2^31 is congruent to c, so the high part folds down by c.
  assign hi_fold = 24'(prod_r[46:31]) * 24'(fold);
  assign modulus = (sel2_r == GEN_TWO) ? MOD_TWO : MOD_ONE;
  // Folded sum stays below twice the modulus: one subtract finishes it.
  assign reduced = (sum_r >= modulus) ? (sum_r - modulus) : sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= req.valid;
      v2_r <= v1_r;
    end
    prod_r <= 47'(req.x) * 47'(mul);
    sel1_r <= req.sel;
    sum_r  <= {1'b0, prod_r[30:0]} + 32'(hi_fold);
    sel2_r <= sel1_r;
  end

  assign rsp.valid = v2_r;
  assign rsp.sel   = sel2_r;
  assign rsp.res   = reduced[VAL_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/combined_lcg_shuffle_rng_top.sv
// Combined two-generator random source with shuffle table (ran2 scheme), top level.
//
// Each request beat with request set returns one value in 1..2147483562, the
// numerator of a uniform fraction over 2147483563; a beat with request clear
// is taken and returns nothing. Both generator steps run through one shared
// two-stage modular multiplier, while the shuffle slot comes from a reciprocal
// multiply by the constant slot width. From accept to result valid at any
// TABLE_SIZE, a draw issues the first and then the second generator step,
// waits on the second generator step, then does table read, difference,
// wrap and output load. The first request after reset also seeds both
// generators from the seed register (0 counts as 1) and runs TABLE_SIZE + 8
// dependent multiplier steps to fill the table. The seed is read only at that
// first request. in_stall stays high from accept until the result is loaded
// into the output register.
`default_nettype none

module combined_lcg_shuffle_rng_top #(
  parameter int unsigned TABLE_SIZE = clsr_pkg::TABLE_SIZE_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire                         in_request,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [clsr_pkg::VAL_W-1:0]  out_value,
  input  wire                         cfg_wr_en,
  input  wire  [clsr_pkg::VAL_W-1:0]  cfg_wr_data
);

  import clsr_pkg::*;

  localparam int unsigned QB = $clog2(TABLE_SIZE);
  localparam int unsigned CW = $clog2(TABLE_SIZE + WARM_EXTRA);
  localparam longint unsigned SLOT_DIV = 1 + 64'(TOP_VALUE) / TABLE_SIZE;
  // Reciprocal with enough fraction bits that the product gives the exact quotient.
  localparam int unsigned DW = $clog2(SLOT_DIV);
  localparam int unsigned SH = VAL_W + DW;
  localparam longint unsigned RECIP = ((64'd1 << SH) + SLOT_DIV - 64'd1) / SLOT_DIV;
  localparam logic [31:0] RECIP_W = 32'(RECIP);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_ISSUE,
    ST_SEED_WAIT,
    ST_ISSUE_ONE,
    ST_ISSUE_TWO,
    ST_WAIT,
    ST_READ,
    ST_DIFF,
    ST_FIX,
    ST_OUT
  } state_t;

  state_t           state_r;
  logic [VAL_W-1:0] seed_r;
  logic [VAL_W-1:0] gen_one_r;
  logic [VAL_W-1:0] gen_two_r;
  logic [VAL_W-1:0] last_out_r;
  logic             need_seed_r;
  logic [CW-1:0]    cnt_r;
  logic             got_one_r;
  logic             got_two_r;
  logic [QB-1:0]    quo_r;
  logic [QB-1:0]    slot_r;
  logic [31:0]      diff_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_value_r;

  mm_req_t          mm_req;
  mm_rsp_t          mm_rsp;
  logic             ram_we;
  logic [QB-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [QB-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  logic [VAL_W-1:0] start_val;
  logic [62:0]      quo_prod;
  logic [QB-1:0]    slot;
  logic             diff_low;
  logic [31:0]      fixed;

  assign start_val  = (seed_r == '0) ? VAL_W'(1) : seed_r;
  assign quo_prod   = 63'(last_out_r) * 63'(RECIP_W);
  // Slot is always in range; an out-of-range quotient still wraps to 0.
  assign slot       = ({1'b0, quo_r} >= (QB + 1)'(TABLE_SIZE)) ? '0 : quo_r;
  assign diff_low   = diff_r[31] || (diff_r == '0);
  assign fixed      = diff_low ? (diff_r + {1'b0, TOP_VALUE}) : diff_r;

  always_comb begin
    mm_req.valid = 1'b0;
    mm_req.sel   = GEN_ONE;
    mm_req.x     = gen_one_r;
    ram_we       = 1'b0;
    ram_waddr    = slot_r;
    ram_wdata    = gen_one_r;
    ram_raddr    = slot;
    unique case (state_r)
      ST_SEED_ISSUE, ST_ISSUE_ONE: begin
        mm_req.valid = 1'b1;
      end
      ST_ISSUE_TWO: begin
        mm_req.valid = 1'b1;
        mm_req.sel   = GEN_TWO;
        mm_req.x     = gen_two_r;
      end
      ST_SEED_WAIT: begin
        // Last TABLE_SIZE warm-up steps fill the table from the top entry down.
        ram_we    = mm_rsp.valid && (cnt_r < CW'(TABLE_SIZE));
        ram_waddr = cnt_r[QB-1:0];
        ram_wdata = mm_rsp.res;
      end
      ST_DIFF: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= VAL_W'(1);
      gen_one_r   <= '0;
      gen_two_r   <= '0;
      last_out_r  <= '0;
      need_seed_r <= 1'b1;
      cnt_r       <= '0;
      got_one_r   <= 1'b0;
      got_two_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (mm_rsp.valid) begin
        if (mm_rsp.sel == GEN_TWO) begin
          gen_two_r <= mm_rsp.res;
          got_two_r <= 1'b1;
        end else begin
          gen_one_r <= mm_rsp.res;
          got_one_r <= 1'b1;
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && in_request) begin
            if (need_seed_r) begin
              gen_one_r <= start_val;
              gen_two_r <= start_val;
              cnt_r     <= CW'(TABLE_SIZE + WARM_EXTRA - 1);
              state_r   <= ST_SEED_ISSUE;
            end else begin
              state_r <= ST_ISSUE_ONE;
            end
          end
        end
        ST_SEED_ISSUE: begin
          state_r <= ST_SEED_WAIT;
        end
        ST_SEED_WAIT: begin
          if (mm_rsp.valid) begin
            if (cnt_r == '0) begin
              last_out_r  <= mm_rsp.res;
              need_seed_r <= 1'b0;
              state_r     <= ST_ISSUE_ONE;
            end else begin
              cnt_r   <= cnt_r - CW'(1);
              state_r <= ST_SEED_ISSUE;
            end
          end
        end
        ST_ISSUE_ONE: begin
          got_one_r <= 1'b0;
          got_two_r <= 1'b0;
          quo_r     <= quo_prod[SH +: QB];
          state_r   <= ST_ISSUE_TWO;
        end
        ST_ISSUE_TWO: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (got_one_r && got_two_r) begin
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          slot_r  <= slot;
          state_r <= ST_DIFF;
        end
        ST_DIFF: begin
          diff_r  <= {1'b0, ram_rdata} - {1'b0, gen_two_r};
          state_r <= ST_FIX;
        end
        ST_FIX: begin
          last_out_r <= fixed[VAL_W-1:0];
          state_r    <= ST_OUT;
        end
        ST_OUT: begin
          // Hold until the output register is free.
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_value_r <= last_out_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  clsr_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  clsr_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule

`default_nettype wire

>>> hw/rtl/clsr_checker.sv
// Port-level assertions for the random generator top level, with bind.
`default_nettype none

module clsr_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_stall,
  input wire                        in_request,
  input wire                        out_valid,
  input wire                        out_stall,
  input wire [clsr_pkg::VAL_W-1:0]  out_value
);

  import clsr_pkg::*;

  // Reset leaves no result pending and the input side open.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("result pending or input stalled after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_value)))
    else $error("stalled result beat changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_value != '0) && (out_value <= TOP_VALUE)))
    else $error("result value out of range");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_request) |=> in_stall)
    else $error("request beat did not start a draw");

  a_idle_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_request) |=> !in_stall)
    else $error("empty beat made the block busy");

endmodule

bind combined_lcg_shuffle_rng_top clsr_checker u_clsr_checker (.*);

`default_nettype wire
